### hw/rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Types and constants shared by the TFTP send sequencer modules.
// ----------------------------------------------------------------------------
package tss_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_DONE
	} phase_t;

	// event codes
	localparam logic [1:0] MODE_START   = 2'd0;
	localparam logic [1:0] MODE_PACKET  = 2'd1;
	localparam logic [1:0] MODE_TIMEOUT = 2'd2;
	localparam logic [1:0] MODE_RXERR   = 2'd3;

	// command codes
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_DATA  = 2'd1;
	localparam logic [1:0] ACT_ERROR = 2'd2;
	localparam logic [1:0] ACT_CLOSE = 2'd3;

	// error kinds
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NOT_FOUND = 3'd1;
	localparam logic [2:0] ERR_OPCODE    = 3'd2;
	localparam logic [2:0] ERR_ACK_AHEAD = 3'd3;
	localparam logic [2:0] ERR_RETRIES   = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_FILE_BYTES  = 2'd0;
	localparam logic [1:0] CFG_BLOCK_BYTES = 2'd1;
	localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;
	localparam logic [1:0] CFG_FILE_FOUND  = 2'd3;

	localparam logic [15:0] OPCODE_ACK  = 16'd4;
	localparam logic [15:0] ACK_LENGTH  = 16'd4;
	localparam logic [15:0] BLOCK_MIN   = 16'd8;
	localparam logic [15:0] BLOCK_MAX   = 16'd65464;
	localparam logic [15:0] BLOCK_RESET = 16'd512;
	localparam logic [3:0]  RETRY_RESET = 4'd4;

	typedef struct packed {
		logic [31:0] file_bytes;
		logic [15:0] block_bytes;  // already clamped to BLOCK_MIN..BLOCK_MAX
		logic [3:0]  retry_limit;
		logic        file_found;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] pkt_opcode;
		logic [15:0] pkt_block;
		logic [15:0] pkt_length;
	} evt_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] out_block;
		logic [31:0] data_offset;
		logic [15:0] data_length;
		logic        last_block;
		logic [2:0]  error_kind;
	} cmd_t;

endpackage

### hw/rtl/tss_if.sv
// ----------------------------------------------------------------------------
// tss_if
// Valid/ready channels of the TFTP send sequencer: events in, commands out.
// ----------------------------------------------------------------------------
interface tss_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] pkt_opcode;
	logic [15:0] pkt_block;
	logic [15:0] pkt_length;

	modport source (output valid, output mode, output pkt_opcode, output pkt_block,
		output pkt_length, input ready);
	modport sink (input valid, input mode, input pkt_opcode, input pkt_block,
		input pkt_length, output ready);
endinterface

interface tss_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] out_block;
	logic [31:0] data_offset;
	logic [15:0] data_length;
	logic        last_block;
	logic [2:0]  error_kind;

	modport source (output valid, output action, output out_block, output data_offset,
		output data_length, output last_block, output error_kind, input ready);
	modport sink (input valid, input action, input out_block, input data_offset,
		input data_length, input last_block, input error_kind, output ready);
endinterface

### hw/rtl/tss_cfg_regs.sv
// ----------------------------------------------------------------------------
// tss_cfg_regs
// Configuration registers; block size is clamped when written.
// ----------------------------------------------------------------------------
module tss_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_wdata,
	output tss_pkg::cfg_t    cfg
);
	import tss_pkg::*;

	logic [15:0] blk_wr;
	cfg_t        cfg_q;

	always_comb begin
		blk_wr = cfg_wdata[15:0];
		if (blk_wr < BLOCK_MIN) begin
			blk_wr = BLOCK_MIN;
		end else if (blk_wr > BLOCK_MAX) begin
			blk_wr = BLOCK_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.file_bytes  <= '0;
			cfg_q.block_bytes <= BLOCK_RESET;
			cfg_q.retry_limit <= RETRY_RESET;
			cfg_q.file_found  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILE_BYTES:  cfg_q.file_bytes  <= cfg_wdata;
				CFG_BLOCK_BYTES: cfg_q.block_bytes <= blk_wr;
				CFG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_wdata[3:0];
				CFG_FILE_FOUND:  cfg_q.file_found  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/tss_seq.sv
// ----------------------------------------------------------------------------
// tss_seq
// Transfer state and the per-event decision logic.
// ----------------------------------------------------------------------------
module tss_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  tss_pkg::cfg_t    cfg,
	input  logic             fire,
	input  tss_pkg::evt_t    evt,
	output tss_pkg::cmd_t    cmd
);
	import tss_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] cur_blk_q, cur_blk_d;
	logic [31:0] offset_q, offset_d;
	logic        last_q, last_d;
	logic [4:0]  retry_q, retry_d, retry_inc;

	// remaining bytes from this offset, and from the offset after a full block
	logic [32:0] rest0;
	logic [33:0] rest1;
	logic        pos0, pos1;
	logic [15:0] len0, len1;
	logic [31:0] offset_nx;

	always_comb begin
		rest0 = {1'b0, cfg.file_bytes} - {1'b0, offset_q};
		rest1 = {2'b0, cfg.file_bytes} - {2'b0, offset_q} - {18'b0, cfg.block_bytes};
		pos0  = !rest0[32] && (rest0 != '0);
		pos1  = !rest1[33] && (rest1 != '0);
		if (!pos0) begin
			len0 = '0;
		end else if (rest0[31:16] == '0 && rest0[15:0] < cfg.block_bytes) begin
			len0 = rest0[15:0];
		end else begin
			len0 = cfg.block_bytes;
		end
		if (!pos1) begin
			len1 = '0;
		end else if (rest1[32:16] == '0 && rest1[15:0] < cfg.block_bytes) begin
			len1 = rest1[15:0];
		end else begin
			len1 = cfg.block_bytes;
		end
		offset_nx = offset_q + {16'b0, len0};
		retry_inc = retry_q + 5'd1;
	end

	always_comb begin
		phase_d   = phase_q;
		cur_blk_d = cur_blk_q;
		offset_d  = offset_q;
		last_d    = last_q;
		retry_d   = retry_q;
		cmd       = '0;
		cmd.action = ACT_NONE;

		if (evt.mode == MODE_START) begin
			if (phase_q == PH_IDLE) begin
				if (!cfg.file_found) begin
					cmd.action     = ACT_ERROR;
					cmd.error_kind = ERR_NOT_FOUND;
					phase_d        = PH_DONE;
				end else begin
					phase_d         = PH_WAIT;
					cmd.action      = ACT_DATA;
					cmd.out_block   = cur_blk_q;
					cmd.data_offset = offset_q;
					cmd.data_length = len0;
					cmd.last_block  = len0 < cfg.block_bytes;
					last_d          = cmd.last_block;
				end
			end
		end else if (phase_q == PH_WAIT) begin
			priority if (evt.mode == MODE_RXERR) begin
				cmd.action = ACT_CLOSE;
				phase_d    = PH_DONE;
			end else if (evt.mode == MODE_TIMEOUT) begin
				retry_d = retry_inc;
				if (retry_inc <= {1'b0, cfg.retry_limit}) begin
					cmd.action      = ACT_DATA;
					cmd.out_block   = cur_blk_q;
					cmd.data_offset = offset_q;
					cmd.data_length = len0;
					cmd.last_block  = len0 < cfg.block_bytes;
					last_d          = cmd.last_block;
				end else begin
					cmd.action     = ACT_ERROR;
					cmd.error_kind = ERR_RETRIES;
					phase_d        = PH_DONE;
				end
			end else if (evt.pkt_length != ACK_LENGTH) begin
				cmd.action = ACT_CLOSE;
				phase_d    = PH_DONE;
			end else if (evt.pkt_opcode != OPCODE_ACK) begin
				cmd.action     = ACT_ERROR;
				cmd.error_kind = ERR_OPCODE;
				phase_d        = PH_DONE;
			end else if (evt.pkt_block < cur_blk_q) begin
				cmd.action      = ACT_DATA;
				cmd.out_block   = cur_blk_q;
				cmd.data_offset = offset_q;
				cmd.data_length = len0;
				cmd.last_block  = len0 < cfg.block_bytes;
				last_d          = cmd.last_block;
			end else if (evt.pkt_block > cur_blk_q) begin
				cmd.action     = ACT_ERROR;
				cmd.error_kind = ERR_ACK_AHEAD;
				phase_d        = PH_DONE;
			end else if (last_q) begin
				cmd.action = ACT_CLOSE;
				phase_d    = PH_DONE;
			end else begin
				// advance: next block starts after this one
				cur_blk_d       = cur_blk_q + 16'd1;
				offset_d        = offset_nx;
				retry_d         = '0;
				cmd.action      = ACT_DATA;
				cmd.out_block   = cur_blk_d;
				cmd.data_offset = offset_nx;
				cmd.data_length = len1;
				cmd.last_block  = len1 < cfg.block_bytes;
				last_d          = cmd.last_block;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cur_blk_q <= 16'd1;
			offset_q  <= '0;
			last_q    <= 1'b0;
			retry_q   <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			cur_blk_q <= cur_blk_d;
			offset_q  <= offset_d;
			last_q    <= last_d;
			retry_q   <= retry_d;
		end
	end

endmodule

### hw/rtl/tftp_send_sequencer_top.sv
// ----------------------------------------------------------------------------
// tftp_send_sequencer_top
// Sender side of a lock-step TFTP transfer: one command per event.
// ----------------------------------------------------------------------------
// Events (start, received packet, timeout, receive error) come in on the evt
// channel; exactly one command per event leaves on the cmd channel, in order:
// nothing, send a data block (number, file offset, length, last flag), send
// an error, or close. Both channels are valid/ready.
// An event is registered on acceptance in the input register, decided
// against the transfer state, and its command is registered in the command
// register. One event per cycle is sustained while cmd is not stalled;
// the rate is set by the single decision stage, which also updates block
// number, offset, last flag and retry count.
// When cmd is stalled the held command waits in its register; one more event
// is taken into the input register, then evt.ready drops until cmd drains.
// Reset clears the transfer to idle at block 1, offset 0, and loads the
// registers with file size 0, block size 512, retry limit 4, file absent.
// Registers are written through cfg_we/cfg_index/cfg_wdata, by the user only
// while no event is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tftp_send_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	tss_evt_if.sink     evt,
	tss_cmd_if.source   cmd,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import tss_pkg::*;

	cfg_t cfg;
	evt_t evt_s1;
	logic valid_s1;
	cmd_t cmd_next;
	cmd_t cmd_q;
	logic cmd_valid_q;
	logic advance;
	logic fire;

	assign advance   = !cmd_valid_q || cmd.ready;
	assign fire      = valid_s1 && advance;
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			evt_s1.mode       <= evt.mode;
			evt_s1.pkt_opcode <= evt.pkt_opcode;
			evt_s1.pkt_block  <= evt.pkt_block;
			evt_s1.pkt_length <= evt.pkt_length;
		end
	end

	tss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tss_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.evt    (evt_s1),
		.cmd    (cmd_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (advance) begin
			cmd_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cmd_q <= cmd_next;
		end
	end

	assign cmd.valid       = cmd_valid_q;
	assign cmd.action      = cmd_q.action;
	assign cmd.out_block   = cmd_q.out_block;
	assign cmd.data_offset = cmd_q.data_offset;
	assign cmd.data_length = cmd_q.data_length;
	assign cmd.last_block  = cmd_q.last_block;
	assign cmd.error_kind  = cmd_q.error_kind;

endmodule

### verif/tb_tftp_send_sequencer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tftp_send_sequencer_top
// Self-checking bench for the TFTP send sequencer.
// ----------------------------------------------------------------------------
// A single transfer is run from start to teardown, since only reset brings the
// sequencer back to idle. A directed opening covers the ignored events, the
// clamped block sizes, zero-length and short blocks and a file that shrinks
// under the offset. Random phases then mostly ACK the current block, with old
// ACKs and timeouts in between, and the registers are rewritten between
// phases. The run closes with one randomly chosen teardown and a burst of
// events that must all be ignored. Every event is predicted when it is
// accepted and each command is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_tftp_send_sequencer_top;
	import tss_pkg::*;

	typedef struct {
		phase_t      phase;
		logic [15:0] blk;
		logic [31:0] offset;
		logic        last_sent;
		logic [4:0]  retries;
	} xfer_t;

	typedef enum {
		END_RXERR,
		END_BAD_LENGTH,
		END_OPCODE,
		END_ACK_AHEAD,
		END_RETRIES,
		END_LAST_ACK
	} teardown_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	tss_evt_if evt_ch ();
	tss_cmd_if cmd_ch ();

	tftp_send_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_ch),
		.cmd       (cmd_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	cfg_t      cfg_model;
	xfer_t     xfer;      // state as of the last accepted event
	xfer_t     gen;       // state as of the last queued event, steers stimulus
	evt_t      evt_backlog[$];
	cmd_t      pending_cmds[$];
	logic      evt_pending;
	int        idle_pct;
	int        stall_pct;
	int        fail_cnt;
	int        events_done;
	int        cmds_seen[4];
	teardown_t teardown;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [15:0] block_len(xfer_t st, cfg_t c);
		logic [31:0] rest;
		if (st.offset >= c.file_bytes)
			return 16'd0;
		rest = c.file_bytes - st.offset;
		return (rest < {16'd0, c.block_bytes}) ? rest[15:0] : c.block_bytes;
	endfunction

	function automatic cmd_t data_cmd(inout xfer_t st, input cfg_t c);
		cmd_t r;
		r = '0;
		r.action      = ACT_DATA;
		r.out_block   = st.blk;
		r.data_offset = st.offset;
		r.data_length = block_len(st, c);
		r.last_block  = (r.data_length < c.block_bytes);
		st.last_sent  = r.last_block;
		return r;
	endfunction

	function automatic cmd_t error_cmd(inout xfer_t st, input logic [2:0] kind);
		cmd_t r;
		r = '0;
		r.action     = ACT_ERROR;
		r.error_kind = kind;
		st.phase     = PH_DONE;
		return r;
	endfunction

	function automatic cmd_t close_cmd(inout xfer_t st);
		cmd_t r;
		r = '0;
		r.action = ACT_CLOSE;
		st.phase = PH_DONE;
		return r;
	endfunction

	// Command caused by one event; updates the transfer state in place.
	function automatic cmd_t decide_event(inout xfer_t st, input cfg_t c, input evt_t e);
		cmd_t r;
		r = '0;
		if (e.mode == MODE_START) begin
			if (st.phase == PH_IDLE) begin
				if (!c.file_found) begin
					r = error_cmd(st, ERR_NOT_FOUND);
				end else begin
					st.phase = PH_WAIT;
					r = data_cmd(st, c);
				end
			end
		end else if (st.phase == PH_WAIT) begin
			if (e.mode == MODE_RXERR) begin
				r = close_cmd(st);
			end else if (e.mode == MODE_TIMEOUT) begin
				st.retries = st.retries + 5'd1;
				if (st.retries <= {1'b0, c.retry_limit})
					r = data_cmd(st, c);
				else
					r = error_cmd(st, ERR_RETRIES);
			end else if (e.pkt_length != ACK_LENGTH) begin
				r = close_cmd(st);
			end else if (e.pkt_opcode != OPCODE_ACK) begin
				r = error_cmd(st, ERR_OPCODE);
			end else if (e.pkt_block < st.blk) begin
				r = data_cmd(st, c);
			end else if (e.pkt_block > st.blk) begin
				r = error_cmd(st, ERR_ACK_AHEAD);
			end else if (st.last_sent) begin
				r = close_cmd(st);
			end else begin
				st.offset  = st.offset + {16'd0, block_len(st, c)};
				st.blk     = st.blk + 16'd1;
				st.retries = '0;
				r = data_cmd(st, c);
			end
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_cnt++;
		end
	endfunction

	// driver: presents one transaction at a time, holds it until taken
	always @(negedge clk) begin
		if (!evt_pending) begin
			if (evt_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
				evt_ch.valid      <= 1'b1;
				evt_ch.mode       <= evt_backlog[0].mode;
				evt_ch.pkt_opcode <= evt_backlog[0].pkt_opcode;
				evt_ch.pkt_block  <= evt_backlog[0].pkt_block;
				evt_ch.pkt_length <= evt_backlog[0].pkt_length;
				evt_pending = 1'b1;
			end else begin
				evt_ch.valid <= 1'b0;
			end
		end
		cmd_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// monitor: predicts on each accepted event, checks each command
	always @(posedge clk) begin : monitor
		evt_t e;
		cmd_t want;
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready) begin
				e = evt_backlog.pop_front();
				pending_cmds.push_back(decide_event(xfer, cfg_model, e));
				evt_pending = 1'b0;
				events_done++;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				if (pending_cmds.size() == 0) begin
					$error("command with no event outstanding: action %0d", cmd_ch.action);
					fail_cnt++;
				end else begin
					want = pending_cmds.pop_front();
					check_field("action", 32'(want.action), 32'(cmd_ch.action));
					check_field("out_block", 32'(want.out_block), 32'(cmd_ch.out_block));
					check_field("data_offset", want.data_offset, cmd_ch.data_offset);
					check_field("data_length", 32'(want.data_length),
						32'(cmd_ch.data_length));
					check_field("last_block", 32'(want.last_block),
						32'(cmd_ch.last_block));
					check_field("error_kind", 32'(want.error_kind),
						32'(cmd_ch.error_kind));
					cmds_seen[want.action]++;
				end
			end
		end
	end

	task automatic queue_event(logic [1:0] mode, logic [15:0] op, logic [15:0] ack,
			logic [15:0] len);
		evt_t e;
		e = '{mode: mode, pkt_opcode: op, pkt_block: ack, pkt_length: len};
		evt_backlog.push_back(e);
		void'(decide_event(gen, cfg_model, e));
	endtask

	task automatic queue_noise();
		queue_event(2'($urandom_range(3)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)));
	endtask

	task automatic drain();
		while (evt_backlog.size() != 0 || evt_pending || pending_cmds.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// only called with nothing in flight; junk above the register width
	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		logic [31:0] junk;
		logic [31:0] wdata;
		junk = $urandom;
		case (idx)
			CFG_BLOCK_BYTES: wdata = {junk[31:16], val[15:0]};
			CFG_RETRY_LIMIT: wdata = {junk[31:4], val[3:0]};
			CFG_FILE_FOUND:  wdata = {junk[31:1], val[0]};
			default:         wdata = val;
		endcase
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= wdata;
		@(posedge clk);
		case (idx)
			CFG_FILE_BYTES:  cfg_model.file_bytes = val;
			CFG_BLOCK_BYTES: begin
				if (val[15:0] < BLOCK_MIN)
					cfg_model.block_bytes = BLOCK_MIN;
				else if (val[15:0] > BLOCK_MAX)
					cfg_model.block_bytes = BLOCK_MAX;
				else
					cfg_model.block_bytes = val[15:0];
			end
			CFG_RETRY_LIMIT: cfg_model.retry_limit = val[3:0];
			CFG_FILE_FOUND:  cfg_model.file_found = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(int sel);
		case (sel % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 47; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 47; end
			default: begin idle_pct = 11; stall_pct = 11; end
		endcase
	endtask

	// new register set for a random phase; the file is kept well ahead of the
	// offset so the transfer does not stall on its last block
	task automatic reconfigure(int ph);
		longint unsigned fsize;
		logic [15:0] bsize;
		case ($urandom_range(5))
			0: bsize = BLOCK_MIN;
			1: bsize = BLOCK_MAX;
			2: bsize = 16'($urandom_range(7));
			3: bsize = 16'($urandom_range(65535, 65465));
			4: bsize = 16'($urandom_range(2000, 8));
			default: bsize = 16'($urandom_range(65464, 8));
		endcase
		cfg_write(CFG_BLOCK_BYTES, {16'd0, bsize});
		if (ph == 0)
			cfg_write(CFG_RETRY_LIMIT, 32'd0);
		else if (ph == 1)
			cfg_write(CFG_RETRY_LIMIT, 32'd15);
		else
			cfg_write(CFG_RETRY_LIMIT, 32'($urandom_range(15)));
		fsize = 64'(gen.offset) + 64'(cfg_model.block_bytes) * $urandom_range(400, 150)
			+ $urandom_range(65535);
		if (fsize > 64'hFFFF_FFFF || $urandom_range(3) == 0)
			fsize = 64'hFFFF_FFFF;
		cfg_write(CFG_FILE_BYTES, 32'(fsize));
		cfg_write(CFG_FILE_FOUND, 32'($urandom_range(1)));
	endtask

	// one event of a healthy transfer: mostly ACKs of the current block
	task automatic random_step();
		int unsigned pick;
		logic [15:0] ack;
		logic        timeout_ok;
		pick = $urandom_range(99);
		timeout_ok = ({1'b0, cfg_model.retry_limit} > gen.retries);
		ack = 16'($urandom_range(int'(gen.blk) - 1));
		if (pick < 3)
			queue_event(MODE_START, 16'($urandom_range(65535)),
				16'($urandom_range(65535)), 16'($urandom_range(65535)));
		else if (pick < 20 && timeout_ok)
			queue_event(MODE_TIMEOUT, 16'($urandom_range(65535)),
				16'($urandom_range(65535)), 16'($urandom_range(65535)));
		else if (pick < 40 || gen.last_sent)
			queue_event(MODE_PACKET, OPCODE_ACK, ack, ACK_LENGTH);
		else
			queue_event(MODE_PACKET, OPCODE_ACK, gen.blk, ACK_LENGTH);
	endtask

	task automatic finish_transfer();
		logic [15:0] word;
		teardown = teardown_t'($urandom_range(5));
		case (teardown)
			END_RXERR: queue_event(MODE_RXERR, 16'($urandom_range(65535)),
				16'($urandom_range(65535)), 16'($urandom_range(65535)));
			END_BAD_LENGTH: begin
				word = 16'($urandom_range(65535));
				if (word == ACK_LENGTH)
					word = word + 16'd1;
				queue_event(MODE_PACKET, OPCODE_ACK, gen.blk, word);
			end
			END_OPCODE: begin
				word = 16'($urandom_range(65535));
				if (word == OPCODE_ACK)
					word = word + 16'd1;
				queue_event(MODE_PACKET, word, gen.blk, ACK_LENGTH);
			end
			END_ACK_AHEAD: queue_event(MODE_PACKET, OPCODE_ACK,
				16'($urandom_range(65535, int'(gen.blk) + 1)), ACK_LENGTH);
			END_RETRIES: begin
				while (gen.phase == PH_WAIT)
					queue_event(MODE_TIMEOUT, 16'($urandom_range(65535)),
						16'($urandom_range(65535)), 16'($urandom_range(65535)));
			end
			default: begin
				// shrink the file to the offset, resend as an empty last block,
				// then ACK it
				cfg_write(CFG_FILE_BYTES, gen.offset);
				queue_event(MODE_PACKET, OPCODE_ACK, 16'd0, ACK_LENGTH);
				queue_event(MODE_PACKET, OPCODE_ACK, gen.blk, ACK_LENGTH);
			end
		endcase
		drain();
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_FILE_BYTES;
		cfg_wdata         = '0;
		evt_ch.valid      = 1'b0;
		evt_ch.mode       = MODE_START;
		evt_ch.pkt_opcode = '0;
		evt_ch.pkt_block  = '0;
		evt_ch.pkt_length = '0;
		cmd_ch.ready      = 1'b0;
		evt_pending       = 1'b0;
		fail_cnt          = 0;
		events_done       = 0;
		cmds_seen         = '{default: 0};
		cfg_model         = '{file_bytes: '0, block_bytes: BLOCK_RESET,
			retry_limit: RETRY_RESET, file_found: 1'b0};
		xfer              = '{phase: PH_IDLE, blk: 16'd1, offset: '0, last_sent: 1'b0,
			retries: '0};
		gen               = xfer;
		set_idling(0);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ignored while idle, with every field at its extremes
		queue_event(MODE_PACKET, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_event(MODE_PACKET, 16'h0000, 16'h0000, 16'h0000);
		queue_event(MODE_TIMEOUT, 16'hFFFF, 16'h0000, 16'hFFFF);
		queue_event(MODE_RXERR, 16'h0000, 16'hFFFF, 16'h0000);
		drain();

		// empty file, block size below the minimum
		cfg_write(CFG_FILE_BYTES, 32'd0);
		cfg_write(CFG_BLOCK_BYTES, 32'd0);
		cfg_write(CFG_RETRY_LIMIT, 32'd15);
		cfg_write(CFG_FILE_FOUND, 32'd1);
		queue_event(MODE_START, 16'h0, 16'h0, 16'h0);
		queue_event(MODE_START, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_event(MODE_TIMEOUT, 16'h0, 16'h0, 16'h0);
		drain();

		// 20 byte file: two full blocks and a short one
		cfg_write(CFG_FILE_BYTES, 32'd20);
		queue_event(MODE_TIMEOUT, 16'h0, 16'h0, 16'h0);
		queue_event(MODE_PACKET, OPCODE_ACK, 16'd1, ACK_LENGTH);
		queue_event(MODE_PACKET, OPCODE_ACK, 16'd1, ACK_LENGTH);
		queue_event(MODE_PACKET, OPCODE_ACK, 16'd2, ACK_LENGTH);
		queue_event(MODE_PACKET, OPCODE_ACK, 16'd0, ACK_LENGTH);
		drain();

		// largest file, block size above the maximum
		cfg_write(CFG_FILE_BYTES, 32'hFFFF_FFFF);
		cfg_write(CFG_BLOCK_BYTES, 32'd65535);
		queue_event(MODE_TIMEOUT, 16'h0, 16'h0, 16'h0);
		queue_event(MODE_PACKET, OPCODE_ACK, 16'd3, ACK_LENGTH);
		drain();

		// file cut below the current offset
		cfg_write(CFG_FILE_BYTES, 32'd100);
		queue_event(MODE_TIMEOUT, 16'h0, 16'h0, 16'h0);
		queue_event(MODE_PACKET, OPCODE_ACK, 16'd2, ACK_LENGTH);
		drain();

		cfg_write(CFG_FILE_BYTES, 32'hFFFF_FFFF);
		cfg_write(CFG_BLOCK_BYTES, {16'd0, BLOCK_MAX});
		queue_event(MODE_PACKET, OPCODE_ACK, 16'd3, ACK_LENGTH);
		queue_event(MODE_PACKET, OPCODE_ACK, 16'd4, ACK_LENGTH);
		queue_event(MODE_START, 16'h0, 16'h0, 16'h0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			reconfigure(ph);
			set_idling(ph);
			for (int i = 0; i < 210; i++)
				random_step();
			drain();
		end

		set_idling($urandom_range(3));
		finish_transfer();

		// finished: everything is ignored from here on
		for (int i = 0; i < 24; i++)
			queue_noise();
		drain();

		if (pending_cmds.size() != 0) begin
			$error("%0d commands never arrived", pending_cmds.size());
			fail_cnt++;
		end
		$display("%0d events checked: %0d data, %0d error, %0d close, %0d ignored",
			events_done, cmds_seen[ACT_DATA], cmds_seen[ACT_ERROR],
			cmds_seen[ACT_CLOSE], cmds_seen[ACT_NONE]);
		$display("transfer reached block %0d at offset %0d, ended by %s",
			xfer.blk, xfer.offset, teardown.name());
		if (fail_cnt == 0)
			$display("tb_tftp_send_sequencer_top: PASS");
		else
			$display("tb_tftp_send_sequencer_top: FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout, %0d events taken", events_done);
		$display("tb_tftp_send_sequencer_top: FAIL");
		$finish;
	end

endmodule

### tftp_send_sequencer_top.f
hw/rtl/tss_pkg.sv
hw/rtl/tss_if.sv
hw/rtl/tss_cfg_regs.sv
hw/rtl/tss_seq.sv
hw/rtl/tftp_send_sequencer_top.sv
verif/tb_tftp_send_sequencer_top.sv
